>>> rtl/core/rbt_pkg.sv
// shared types and codes for the reliable broadcast tracker
`default_nettype none
package rbt_pkg;

	localparam int NODE_W  = 10;
	localparam int VALUE_W = 32;
	localparam int THR_W   = 10;

	// received message kinds
	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_READY = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// outgoing message kinds
	localparam logic SEND_ECHO  = 1'b0;
	localparam logic SEND_READY = 1'b1;

	// protocol phases
	localparam logic [1:0] PH_WAIT     = 2'd0;
	localparam logic [1:0] PH_ECHOED   = 2'd1;
	localparam logic [1:0] PH_READIED  = 2'd2;
	localparam logic [1:0] PH_ACCEPTED = 2'd3;

	// reciprocal of 3 for floor(n/3), exact for n below 2048
	localparam int RECIP3   = 683;
	localparam int RECIP3_SH = 11;

	typedef struct packed {
		logic [1:0]         msg_kind;
		logic [NODE_W-1:0]  msg_origin;
		logic [VALUE_W-1:0] msg_value;
	} msg_t;

	typedef struct packed {
		logic               send_valid;
		logic               send_kind;
		logic [NODE_W-1:0]  send_origin;
		logic [VALUE_W-1:0] send_value;
		logic               accepted;
		logic [VALUE_W-1:0] accepted_value;
		logic               table_full;
	} rsp_t;

	typedef struct packed {
		logic [THR_W-1:0] echo_thr;
		logic [THR_W-1:0] ready_thr;
		logic [THR_W-1:0] accept_thr;
	} thr_t;

endpackage
`default_nettype wire

>>> rtl/core/reliable_broadcast_tracker.sv
// top level: byzantine reliable broadcast receiver with table scan sequencer
//
//  channel   signals               handshake
//  --------  --------------------  -------------------------------------
//  message   msg                   taken when start is high and busy low
//  response  rsp                   one cycle, marked by rsp_valid
//  config    cfg_data (node_count) written when cfg_we is high
//
// an item of kind three gives an all-zero response in the cycle after it is taken
// other items scan the value table one slot a cycle through a single value
// comparator; a hit ends the scan early, so busy stays high through the scan
// and the update state, and the response is registered from the update state,
// with the table read through the single memory read port
// reset clears the phase, the valid bits and the node count (back to 4);
// the table memory itself is not cleared, an entry is always written first
// the receiver cannot stall: the response shows for exactly one cycle
`default_nettype none
module reliable_broadcast_tracker #(
	parameter int VALUE_SLOTS = 16,
	parameter int MAX_NODES   = 1023
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire rbt_pkg::msg_t              msg,
	output rbt_pkg::rsp_t                   rsp,
	output logic                            rsp_valid,
	input  wire logic                       cfg_we,
	input  wire logic [rbt_pkg::NODE_W-1:0] cfg_data
);

	localparam int IW = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
	localparam int TW = $clog2(MAX_NODES + 1);
	localparam int CW = (TW > rbt_pkg::THR_W) ? TW : rbt_pkg::THR_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(VALUE_SLOTS - 1);
	localparam logic [TW-1:0] TALLY_MAX = TW'(MAX_NODES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                 state_q;
	logic [1:0]                 phase_q;
	logic [rbt_pkg::NODE_W-1:0] node_count_q;
	rbt_pkg::msg_t              item_q;
	rbt_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;

	// scan pipeline: address issue, then compare on the registered read
	logic [IW-1:0] scan_q;
	logic          issue_q;
	logic          chk_s1;
	logic [IW-1:0] idx_s1;

	logic [IW-1:0] free_q;
	logic          free_found_q;
	logic [IW-1:0] slot_q;
	logic          slot_ok_q;
	logic          full_q;
	logic [TW-1:0] ec_q;
	logic [TW-1:0] rc_q;

	rbt_pkg::thr_t              thr;
	logic [rbt_pkg::VALUE_W-1:0] rd_value;
	logic [TW-1:0]              rd_echo;
	logic [TW-1:0]              rd_ready;
	logic [VALUE_SLOTS-1:0]     valid;

	logic          hit;
	logic          free_now;
	logic [IW-1:0] free_idx;
	logic          is_init;
	logic [TW-1:0] ec_new;
	logic [TW-1:0] rc_new;
	logic          ec_eq;
	logic          rc_eq;
	logic          rc_ge;
	logic          send;
	logic          send_kind;
	logic          acc;
	logic [1:0]    phase_nxt;
	logic          wr_en;

	rbt_thresh u_thresh (
		.node_count (node_count_q),
		.thr        (thr)
	);

	rbt_table #(
		.SLOTS (VALUE_SLOTS),
		.TW    (TW),
		.IW    (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (scan_q),
		.rd_value (rd_value),
		.rd_echo  (rd_echo),
		.rd_ready (rd_ready),
		.wr_en    (wr_en),
		.wr_addr  (slot_q),
		.wr_value (item_q.msg_value),
		.wr_echo  (ec_new),
		.wr_ready (rc_new),
		.valid    (valid)
	);

	// compare stage of the scan
	always_comb begin
		hit      = chk_s1 && valid[idx_s1] && (rd_value == item_q.msg_value);
		free_now = free_found_q || !valid[idx_s1];
		free_idx = free_found_q ? free_q : idx_s1;
		is_init  = (item_q.msg_kind == rbt_pkg::KIND_INIT);
	end

	// tally update, saturating at the node limit; a dropped item counts nothing
	always_comb begin
		ec_new = ec_q;
		rc_new = rc_q;
		if (slot_ok_q && item_q.msg_kind == rbt_pkg::KIND_ECHO) begin
			ec_new = (ec_q >= TALLY_MAX) ? TALLY_MAX : ec_q + 1'b1;
		end
		if (slot_ok_q && item_q.msg_kind == rbt_pkg::KIND_READY) begin
			rc_new = (rc_q >= TALLY_MAX) ? TALLY_MAX : rc_q + 1'b1;
		end
		wr_en = (state_q == ST_UPD) && slot_ok_q;
	end

	// phase rules
	always_comb begin
		ec_eq     = (CW'(ec_new) == CW'(thr.echo_thr));
		rc_eq     = (CW'(rc_new) == CW'(thr.ready_thr));
		rc_ge     = (CW'(rc_new) >= CW'(thr.accept_thr));
		send      = 1'b0;
		send_kind = rbt_pkg::SEND_ECHO;
		acc       = 1'b0;
		phase_nxt = phase_q;
		unique case (phase_q)
			rbt_pkg::PH_WAIT: begin
				if (is_init || ec_eq || rc_eq) begin
					send      = 1'b1;
					phase_nxt = rbt_pkg::PH_ECHOED;
				end
			end
			rbt_pkg::PH_ECHOED: begin
				if (ec_eq || rc_eq) begin
					send      = 1'b1;
					send_kind = rbt_pkg::SEND_READY;
					phase_nxt = rbt_pkg::PH_READIED;
				end
			end
			rbt_pkg::PH_READIED: begin
				if (rc_ge) begin
					acc       = 1'b1;
					phase_nxt = rbt_pkg::PH_ACCEPTED;
				end
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= rbt_pkg::NODE_W'(4);
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= rbt_pkg::PH_WAIT;
			rsp_valid_q  <= 1'b0;
			issue_q      <= 1'b0;
			chk_s1       <= 1'b0;
			free_found_q <= 1'b0;
			slot_ok_q    <= 1'b0;
			full_q       <= 1'b0;
			scan_q       <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (msg.msg_kind == rbt_pkg::KIND_NONE) begin
							// ignored item: zero response, no state change
							rsp_valid_q <= 1'b1;
						end else begin
							state_q      <= ST_SCAN;
							scan_q       <= '0;
							issue_q      <= 1'b1;
							chk_s1       <= 1'b0;
							free_found_q <= 1'b0;
							slot_ok_q    <= 1'b0;
							full_q       <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					chk_s1 <= issue_q;
					if (issue_q) begin
						if (scan_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (hit) begin
						slot_ok_q <= 1'b1;
						state_q   <= ST_UPD;
					end else if (chk_s1) begin
						if (!valid[idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							// miss: allocate unless initiate or table full
							slot_ok_q <= !is_init && free_now;
							full_q    <= !is_init && !free_now;
							state_q   <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					phase_q     <= phase_nxt;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (state_q == ST_IDLE && start) begin
			item_q <= msg;
			rsp_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				slot_q <= idx_s1;
				ec_q   <= rd_echo;
				rc_q   <= rd_ready;
			end else if (chk_s1) begin
				if (!valid[idx_s1] && !free_found_q) begin
					free_q <= idx_s1;
				end
				if (idx_s1 == LAST_IDX) begin
					slot_q <= free_idx;
					ec_q   <= '0;
					rc_q   <= '0;
				end
			end
		end
		if (state_q == ST_UPD) begin
			rsp_q.send_valid     <= send;
			rsp_q.send_kind      <= send ? send_kind : 1'b0;
			rsp_q.send_origin    <= send ? item_q.msg_origin : '0;
			rsp_q.send_value     <= send ? item_q.msg_value : '0;
			rsp_q.accepted       <= acc;
			rsp_q.accepted_value <= acc ? item_q.msg_value : '0;
			rsp_q.table_full     <= full_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

>>> rtl/core/rbt_thresh.sv
// fault bound and echo, ready and accept thresholds from the node count
`default_nettype none
module rbt_thresh (
	input  wire logic [rbt_pkg::NODE_W-1:0] node_count,
	output rbt_pkg::thr_t                   thr
);

	localparam int PW = rbt_pkg::NODE_W + rbt_pkg::RECIP3_SH;

	logic [PW-1:0]              prod;
	logic [rbt_pkg::NODE_W-1:0] third;
	logic [rbt_pkg::NODE_W-1:0] f;
	logic [rbt_pkg::NODE_W:0]   n_plus_f;
	logic                       div3;

	always_comb begin
		prod     = PW'(node_count) * PW'(rbt_pkg::RECIP3);
		third    = rbt_pkg::NODE_W'(prod >> rbt_pkg::RECIP3_SH);
		div3     = (node_count == rbt_pkg::NODE_W'(third + (third << 1)));
		// one less when n is a multiple of 3, never below zero
		f        = (div3 && third != '0) ? third - 1'b1 : third;
		n_plus_f = {1'b0, node_count} + {1'b0, f};
		thr.echo_thr   = rbt_pkg::THR_W'(n_plus_f >> 1);
		thr.ready_thr  = rbt_pkg::THR_W'(f + 1'b1);
		thr.accept_thr = rbt_pkg::THR_W'({f, 1'b0} | 1'b1);
	end

endmodule
`default_nettype wire

>>> rtl/core/rbt_table.sv
// value table: values and tallies in a memory, valid bits in flops
`default_nettype none
module rbt_table #(
	parameter int SLOTS = 16,
	parameter int TW    = 10,
	parameter int IW    = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [IW-1:0]               rd_addr,
	output logic [rbt_pkg::VALUE_W-1:0]      rd_value,
	output logic [TW-1:0]                    rd_echo,
	output logic [TW-1:0]                    rd_ready,
	input  wire logic                        wr_en,
	input  wire logic [IW-1:0]               wr_addr,
	input  wire logic [rbt_pkg::VALUE_W-1:0] wr_value,
	input  wire logic [TW-1:0]               wr_echo,
	input  wire logic [TW-1:0]               wr_ready,
	output logic [SLOTS-1:0]                 valid
);

	localparam int DW = rbt_pkg::VALUE_W + 2 * TW;

	logic [DW-1:0]    mem [SLOTS];
	logic [DW-1:0]    rd_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_value, wr_echo, wr_ready};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_value = rd_q[DW-1 -: rbt_pkg::VALUE_W];
	assign rd_echo  = rd_q[2*TW-1 -: TW];
	assign rd_ready = rd_q[TW-1:0];
	assign valid    = valid_q;

endmodule
`default_nettype wire
